// ===== rtl/tsdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdf_pkg: shared types and constants of the tsdf cell fusion grid
// widths of the word fields, command and status codes, controller states and
// the command and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package tsdf_pkg;

    localparam int CMD_W     = 2;
    localparam int CELL_W    = 5;
    localparam int SDF_W     = 32;
    localparam int FRAC_W    = 12;
    localparam int TSD_W     = 16;
    localparam int WGT_W     = 16;
    localparam int STAT_W    = 2;
    localparam int TRUNC_W   = 31;
    localparam int STEP_W    = 13;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_CELLS_X = 16;
    localparam int DEF_CELLS_Y = 16;

    localparam int ONE_Q12 = 4096;
    localparam int ONE_Q8  = 256;

    localparam logic [TRUNC_W-1:0] TRUNC_RST = 31'd65536;
    localparam logic [STEP_W-1:0]  STEP_RST  = 13'd256;
    localparam logic [WGT_W-1:0]   MAXW_RST  = 16'd8192;

    // divider: 44-bit dividend magnitude, one quotient bit a cycle
    localparam int DIV_N     = 44;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_FUSE  = 2'd0,
        CMD_EMPTY = 2'd1,
        CMD_READ  = 2'd2,
        CMD_INIT  = 2'd3
    } cmd_code_t;

    typedef enum logic [STAT_W-1:0] {
        RES_DONE      = 2'd0,
        RES_SKIPPED   = 2'd1,
        RES_NOT_READY = 2'd2
    } res_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRUNC = 2'd0,
        REG_STEP  = 2'd1,
        REG_MAXW  = 2'd2
    } reg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_PEND,
        OP_NRDY,
        OP_SKIP,
        OP_TDIV,
        OP_DIV,
        OP_TCAP,
        OP_ESTART,
        OP_MUL,
        OP_SUMDIV,
        OP_WRITE,
        OP_NEXT,
        OP_BSTART,
        OP_BWGT,
        OP_BACC,
        OP_BFIN,
        OP_ISTART,
        OP_IWR
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_PEND,
        S_NRDY,
        S_SKIP,
        S_TDIV,
        S_TLOOP,
        S_TCAP,
        S_ESTART,
        S_EWAIT,
        S_MUL,
        S_SUMDIV,
        S_FLOOP,
        S_WRITE,
        S_NEXT,
        S_BSTART,
        S_BWGT,
        S_BACC,
        S_BFIN,
        S_ISTART,
        S_IWR,
        S_POST
    } fsm_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   load;
        logic   post;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_code_t cmd;
        logic      grid_ready;
        logic      skip;
        logic      div_done;
        logic      addr_last;
        logic      corner_last;
        logic      out_full;
    } dp_stat_t;

endpackage

// ===== rtl/tsdf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdf channel interfaces
// valid/ready channels for the input word and the result word
// ----------------------------------------------------------------------------
interface tsdf_in_if;
    logic                               valid;
    logic                               ready;
    logic [tsdf_pkg::CMD_W-1:0]         cmd;
    logic [tsdf_pkg::CELL_W-1:0]        cell_x;
    logic [tsdf_pkg::CELL_W-1:0]        cell_y;
    logic signed [tsdf_pkg::SDF_W-1:0]  sdf;
    logic [tsdf_pkg::FRAC_W-1:0]        frac_x;
    logic [tsdf_pkg::FRAC_W-1:0]        frac_y;

    modport source (output valid, cmd, cell_x, cell_y, sdf, frac_x, frac_y, input ready);
    modport sink   (input valid, cmd, cell_x, cell_y, sdf, frac_x, frac_y, output ready);
endinterface

interface tsdf_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [tsdf_pkg::TSD_W-1:0]  tsd_out;
    logic [tsdf_pkg::WGT_W-1:0]         weight_out;
    logic                               unseen;
    logic [tsdf_pkg::STAT_W-1:0]        status;

    modport source (output valid, tsd_out, weight_out, unseen, status, input ready);
    modport sink   (input valid, tsd_out, weight_out, unseen, status, output ready);
endinterface

// ===== rtl/tsdf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdf_ctrl: command sequencer
// steps the datapath through fuse, emptiness, read and initialise sequences
// ----------------------------------------------------------------------------
module tsdf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tsdf_pkg::dp_stat_t   stat,
    output tsdf_pkg::ctrl_cmd_t  ctrl
);
    import tsdf_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.cmd)
                    CMD_FUSE:
                    begin
                        if (!stat.grid_ready)
                        begin
                            state_next = S_NRDY;
                        end
                        else if (stat.skip)
                        begin
                            state_next = S_SKIP;
                        end
                        else
                        begin
                            state_next = S_TDIV;
                        end
                    end
                    CMD_EMPTY: state_next = stat.grid_ready ? S_ESTART : S_PEND;
                    CMD_READ:  state_next = stat.grid_ready ? S_BSTART : S_NRDY;
                    CMD_INIT:  state_next = stat.grid_ready ? S_POST : S_ISTART;
                    default:   state_next = S_POST;
                endcase
            end
            S_PEND:   state_next = S_POST;
            S_NRDY:   state_next = S_POST;
            S_SKIP:   state_next = S_POST;
            S_TDIV:   state_next = S_TLOOP;
            S_TLOOP:
            begin
                if (stat.div_done)
                begin
                    state_next = S_TCAP;
                end
            end
            S_TCAP:   state_next = S_MUL;
            S_ESTART: state_next = S_EWAIT;
            S_EWAIT:  state_next = S_MUL;
            S_MUL:    state_next = S_SUMDIV;
            S_SUMDIV: state_next = S_FLOOP;
            S_FLOOP:
            begin
                if (stat.div_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (stat.cmd == CMD_EMPTY && !stat.addr_last)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_POST;
                end
            end
            S_NEXT:   state_next = S_EWAIT;
            S_BSTART: state_next = S_BWGT;
            S_BWGT:   state_next = S_BACC;
            S_BACC:   state_next = stat.corner_last ? S_BFIN : S_BWGT;
            S_BFIN:   state_next = S_POST;
            S_ISTART: state_next = S_IWR;
            S_IWR:
            begin
                if (stat.addr_last)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (!stat.out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        ctrl.op   = OP_NONE;
        ctrl.load = 1'b0;
        ctrl.post = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            S_PEND:   ctrl.op = OP_PEND;
            S_NRDY:   ctrl.op = OP_NRDY;
            S_SKIP:   ctrl.op = OP_SKIP;
            S_TDIV:   ctrl.op = OP_TDIV;
            S_TLOOP:  ctrl.op = OP_DIV;
            S_TCAP:   ctrl.op = OP_TCAP;
            S_ESTART: ctrl.op = OP_ESTART;
            S_MUL:    ctrl.op = OP_MUL;
            S_SUMDIV: ctrl.op = OP_SUMDIV;
            S_FLOOP:  ctrl.op = OP_DIV;
            S_WRITE:  ctrl.op = OP_WRITE;
            S_NEXT:   ctrl.op = OP_NEXT;
            S_BSTART: ctrl.op = OP_BSTART;
            S_BWGT:   ctrl.op = OP_BWGT;
            S_BACC:   ctrl.op = OP_BACC;
            S_BFIN:   ctrl.op = OP_BFIN;
            S_ISTART: ctrl.op = OP_ISTART;
            S_IWR:    ctrl.op = OP_IWR;
            S_POST:   ctrl.post = !stat.out_full;
            default:  ctrl.op = OP_NONE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_load_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> state_reg == S_DISPATCH)
        else $error("accepted word not dispatched");

    a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.post |-> !stat.out_full)
        else $error("result posted into a full output register");
`endif

endmodule

// ===== rtl/tsdf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdf_dp: grid datapath
// cell memory, configuration registers, shared restoring divider,
// fold and bilinear arithmetic, result and output registers
// ----------------------------------------------------------------------------
module tsdf_dp #(
    parameter int CELLS_X = tsdf_pkg::DEF_CELLS_X,
    parameter int CELLS_Y = tsdf_pkg::DEF_CELLS_Y
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tsdf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tsdf_pkg::CFG_W-1:0]           cfg_data,
    input  logic [tsdf_pkg::CMD_W-1:0]           in_cmd,
    input  logic [tsdf_pkg::CELL_W-1:0]          in_cell_x,
    input  logic [tsdf_pkg::CELL_W-1:0]          in_cell_y,
    input  logic signed [tsdf_pkg::SDF_W-1:0]    in_sdf,
    input  logic [tsdf_pkg::FRAC_W-1:0]          in_frac_x,
    input  logic [tsdf_pkg::FRAC_W-1:0]          in_frac_y,
    input  tsdf_pkg::ctrl_cmd_t                  ctrl,
    output tsdf_pkg::dp_stat_t                   stat,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tsdf_pkg::TSD_W-1:0]    out_tsd,
    output logic [tsdf_pkg::WGT_W-1:0]           out_weight,
    output logic                                 out_unseen,
    output logic [tsdf_pkg::STAT_W-1:0]          out_status
);
    import tsdf_pkg::*;

    localparam int GW = CELLS_X + 1;
    localparam int N  = (CELLS_X + 1) * (CELLS_Y + 1);
    localparam int AW = $clog2(N);
    localparam int MW = 1 + WGT_W + TSD_W;

    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(ONE_Q8);

    function automatic logic signed [TSD_W-1:0] clamp16(input logic signed [44:0] v);
        logic signed [TSD_W-1:0] r;
        if (v > 45'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -45'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[TSD_W-1:0];
        end
        return r;
    endfunction

    // configuration and grid control
    logic [TRUNC_W-1:0] trunc_reg, trunc_next;
    logic [STEP_W-1:0]  step_reg,  step_next;
    logic [WGT_W-1:0]   maxw_reg,  maxw_next;
    logic               ready_reg, ready_next;
    logic [WGT_W-1:0]   pend_reg,  pend_next;
    logic               oval_reg,  oval_next;

    // item word
    cmd_code_t               cmd_reg;
    logic [CELL_W-1:0]       cx_reg, cy_reg;
    logic signed [SDF_W-1:0] sdf_reg;
    logic [FRAC_W-1:0]       fx_reg, fy_reg;

    // memory
    logic [MW-1:0] mem [N];
    logic [MW-1:0] rd_reg;
    logic [AW-1:0] addr_reg, addr_next;
    logic          wr_en;
    logic [MW-1:0] wr_word;

    // divider
    logic [DIV_N-1:0]     quo_reg, quo_next;
    logic [31:0]          rem_reg, rem_next;
    logic [TRUNC_W-1:0]   dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // fold
    logic signed [TSD_W-1:0] t_reg, t_next;
    logic signed [TSD_W-1:0] oldd_reg, oldd_next;
    logic                    u_reg, u_next;
    logic [WGT_W-1:0]        wsat_reg, wsat_next;
    logic [WGT_W-1:0]        wmax_reg, wmax_next;
    logic [WGT_W:0]          den_reg, den_next;
    logic signed [32:0]      p1_reg, p1_next;
    logic signed [29:0]      p2_reg, p2_next;

    // bilinear
    logic [1:0]         corner_reg, corner_next;
    logic [24:0]        wxy_reg, wxy_next;
    logic signed [42:0] acc_reg, acc_next;
    logic               bun_reg, bun_next;

    // result
    logic signed [TSD_W-1:0] rtsd_reg, rtsd_next;
    logic [WGT_W-1:0]        rw_reg, rw_next;
    logic                    run_reg, run_next;
    res_code_t               rst_reg, rst_next;
    logic signed [TSD_W-1:0] otsd_reg;
    logic [WGT_W-1:0]        ow_reg;
    logic                    oun_reg;
    res_code_t               ost_reg;

    // combinational helpers
    logic [TRUNC_W-1:0]      tr_eff;
    logic                    skip;
    logic [31:0]             fx_sat, fy_sat, bx_sat, by_sat;
    logic [AW-1:0]           fuse_idx, bil_base, bil_addr;
    logic [1:0]              corner_inc;
    logic [32:0]             rem_sh;
    logic                    ge;
    logic signed [44:0]      q_s, tcap_v, cap_v;
    logic [STEP_W-1:0]       stepv;
    logic signed [TSD_W-1:0] rd_d;
    logic [WGT_W-1:0]        rd_w;
    logic [WGT_W:0]          wsum;
    logic [WGT_W-1:0]        wmax_c, prior;
    logic signed [33:0]      num_s;
    logic [33:0]             num_mag;
    logic signed [43:0]      tnum;
    logic [43:0]             tmag;
    logic [STEP_W-1:0]       gx, gy, wx, wy;
    logic signed [42:0]      rnd;
    logic [WGT_W:0]          psum;
    logic signed [TSD_W-1:0] fold_d;

    always_comb
    begin
        tr_eff = (trunc_reg == '0) ? TRUNC_W'(1) : trunc_reg;
        skip   = $signed({{2{sdf_reg[SDF_W-1]}}, sdf_reg}) < -$signed({2'b00, tr_eff, 1'b0});

        fx_sat   = (32'(cx_reg) > 32'(CELLS_X)) ? 32'(CELLS_X) : 32'(cx_reg);
        fy_sat   = (32'(cy_reg) > 32'(CELLS_Y)) ? 32'(CELLS_Y) : 32'(cy_reg);
        bx_sat   = (32'(cx_reg) > 32'(CELLS_X - 1)) ? 32'(CELLS_X - 1) : 32'(cx_reg);
        by_sat   = (32'(cy_reg) > 32'(CELLS_Y - 1)) ? 32'(CELLS_Y - 1) : 32'(cy_reg);
        fuse_idx = AW'(fy_sat * 32'(GW) + fx_sat);
        bil_base = AW'(by_sat * 32'(GW) + bx_sat);
        corner_inc = corner_reg + 2'd1;
        bil_addr = bil_base + (corner_inc[1] ? AW'(GW) : '0) + AW'(corner_inc[0]);

        rem_sh = {rem_reg, quo_reg[DIV_N-1]};
        ge     = rem_sh >= {2'b00, dvs_reg};
        q_s    = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        cap_v  = 45'($signed({1'b0, step_reg, 4'b0000}));
        tcap_v = (q_s > cap_v) ? cap_v : q_s;

        stepv  = (cmd_reg == CMD_EMPTY) ? STEP_ONE : step_reg;
        rd_d   = rd_reg[TSD_W-1:0];
        rd_w   = rd_reg[TSD_W +: WGT_W];
        wsum   = {1'b0, rd_w} + (WGT_W+1)'(stepv);
        wmax_c = (wsum > {1'b0, maxw_reg}) ? maxw_reg : wsum[WGT_W-1:0];
        prior  = (wmax_c > WGT_W'(stepv)) ? wmax_c - WGT_W'(stepv) : '0;

        num_s   = 34'(p1_reg) + 34'(p2_reg);
        num_mag = num_s[33] ? 34'(-num_s) : 34'(num_s);
        tnum    = {sdf_reg, 12'h000};
        tmag    = tnum[43] ? 44'(-tnum) : 44'(tnum);

        gx = STEP_W'(ONE_Q12) - STEP_W'(fx_reg);
        gy = STEP_W'(ONE_Q12) - STEP_W'(fy_reg);
        wx = corner_reg[0] ? STEP_W'(fx_reg) : gx;
        wy = corner_reg[1] ? STEP_W'(fy_reg) : gy;
        rnd = (acc_reg + 43'sd8388608) >>> 24;

        psum   = {1'b0, pend_reg} + (WGT_W+1)'(ONE_Q8);
        fold_d = (den_reg == '0) ? oldd_reg : clamp16(q_s);
    end

    always_comb
    begin
        trunc_next  = trunc_reg;
        step_next   = step_reg;
        maxw_next   = maxw_reg;
        ready_next  = ready_reg;
        pend_next   = pend_reg;
        oval_next   = oval_reg;
        addr_next   = addr_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        t_next      = t_reg;
        oldd_next   = oldd_reg;
        u_next      = u_reg;
        wsat_next   = wsat_reg;
        wmax_next   = wmax_reg;
        den_next    = den_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        corner_next = corner_reg;
        wxy_next    = wxy_reg;
        acc_next    = acc_reg;
        bun_next    = bun_reg;
        rtsd_next   = rtsd_reg;
        rw_next     = rw_reg;
        run_next    = run_reg;
        rst_next    = rst_reg;
        wr_en       = 1'b0;
        wr_word     = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_TRUNC: trunc_next = cfg_data[TRUNC_W-1:0];
                REG_STEP:  step_next  = cfg_data[STEP_W-1:0];
                REG_MAXW:  maxw_next  = cfg_data[WGT_W-1:0];
                default:   trunc_next = trunc_reg;
            endcase
        end

        if (ctrl.load)
        begin
            rtsd_next = '0;
            rw_next   = '0;
            run_next  = 1'b0;
            rst_next  = RES_DONE;
        end

        case (ctrl.op)
            OP_PEND:
            begin
                pend_next = (psum > {1'b0, maxw_reg}) ? maxw_reg : psum[WGT_W-1:0];
                rst_next  = RES_NOT_READY;
            end
            OP_NRDY: rst_next = RES_NOT_READY;
            OP_SKIP: rst_next = RES_SKIPPED;
            OP_TDIV:
            begin
                quo_next  = tmag;
                rem_next  = '0;
                dvs_next  = tr_eff;
                neg_next  = tnum[43];
                cnt_next  = DIV_CNT_W'(DIV_N);
                addr_next = fuse_idx;
            end
            OP_DIV:
            begin
                rem_next = ge ? 32'(rem_sh - {2'b00, dvs_reg}) : rem_sh[31:0];
                quo_next = {quo_reg[DIV_N-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
            OP_TCAP: t_next = clamp16(tcap_v);
            OP_ESTART:
            begin
                t_next    = TSD_W'(ONE_Q12);
                addr_next = '0;
            end
            OP_MUL:
            begin
                oldd_next = rd_d;
                u_next    = rd_reg[MW-1];
                wsat_next = wsum[WGT_W] ? {WGT_W{1'b1}} : wsum[WGT_W-1:0];
                wmax_next = wmax_c;
                den_next  = (WGT_W+1)'(prior) + (WGT_W+1)'(stepv);
                p1_next   = rd_d * $signed({1'b0, prior});
                p2_next   = t_reg * $signed({1'b0, stepv});
            end
            OP_SUMDIV:
            begin
                quo_next = {{(DIV_N-34){1'b0}}, num_mag};
                rem_next = '0;
                dvs_next = {{(TRUNC_W-WGT_W-1){1'b0}}, den_reg};
                neg_next = num_s[33];
                cnt_next = DIV_CNT_W'(DIV_N);
            end
            OP_WRITE:
            begin
                wr_en   = 1'b1;
                wr_word = u_reg ? {1'b0, wsat_reg, t_reg} : {1'b0, wmax_reg, fold_d};
                if (cmd_reg == CMD_FUSE)
                begin
                    rtsd_next = wr_word[TSD_W-1:0];
                    rw_next   = wr_word[TSD_W +: WGT_W];
                end
            end
            OP_NEXT: addr_next = addr_reg + 1'b1;
            OP_BSTART:
            begin
                addr_next   = bil_base;
                corner_next = '0;
                acc_next    = '0;
                bun_next    = 1'b0;
            end
            OP_BWGT: wxy_next = wx * wy;
            OP_BACC:
            begin
                acc_next    = acc_reg + rd_d * $signed({1'b0, wxy_reg});
                bun_next    = bun_reg | rd_reg[MW-1];
                corner_next = corner_inc;
                addr_next   = bil_addr;
            end
            OP_BFIN:
            begin
                rtsd_next = bun_reg ? '0 : clamp16(45'(rnd));
                run_next  = bun_reg;
            end
            OP_ISTART: addr_next = '0;
            OP_IWR:
            begin
                wr_en     = 1'b1;
                wr_word   = (pend_reg != '0) ? {1'b0, pend_reg, TSD_W'(ONE_Q12)}
                                             : {1'b1, pend_reg, {TSD_W{1'b0}}};
                addr_next = addr_reg + 1'b1;
                if (addr_reg == AW'(N - 1))
                begin
                    ready_next = 1'b1;
                end
            end
            default: addr_next = addr_reg;
        endcase

        if (oval_reg && out_ready)
        begin
            oval_next = 1'b0;
        end
        if (ctrl.post)
        begin
            oval_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trunc_reg <= TRUNC_RST;
            step_reg  <= STEP_RST;
            maxw_reg  <= MAXW_RST;
            ready_reg <= 1'b0;
            pend_reg  <= '0;
            oval_reg  <= 1'b0;
            cnt_reg   <= '0;
            rst_reg   <= RES_DONE;
        end
        else
        begin
            trunc_reg <= trunc_next;
            step_reg  <= step_next;
            maxw_reg  <= maxw_next;
            ready_reg <= ready_next;
            pend_reg  <= pend_next;
            oval_reg  <= oval_next;
            cnt_reg   <= cnt_next;
            rst_reg   <= rst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd_code_t'(in_cmd);
            cx_reg  <= in_cell_x;
            cy_reg  <= in_cell_y;
            sdf_reg <= in_sdf;
            fx_reg  <= in_frac_x;
            fy_reg  <= in_frac_y;
        end
        addr_reg   <= addr_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
        t_reg      <= t_next;
        oldd_reg   <= oldd_next;
        u_reg      <= u_next;
        wsat_reg   <= wsat_next;
        wmax_reg   <= wmax_next;
        den_reg    <= den_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        corner_reg <= corner_next;
        wxy_reg    <= wxy_next;
        acc_reg    <= acc_next;
        bun_reg    <= bun_next;
        rtsd_reg   <= rtsd_next;
        rw_reg     <= rw_next;
        run_reg    <= run_next;
        if (ctrl.post)
        begin
            otsd_reg <= rtsd_reg;
            ow_reg   <= rw_reg;
            oun_reg  <= run_reg;
            ost_reg  <= rst_reg;
        end
    end

    // cell memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= wr_word;
        end
        rd_reg <= mem[addr_reg];
    end

    always_comb
    begin
        stat.cmd         = cmd_reg;
        stat.grid_ready  = ready_reg;
        stat.skip        = skip;
        stat.div_done    = (cnt_reg == DIV_CNT_W'(1));
        stat.addr_last   = (addr_reg == AW'(N - 1));
        stat.corner_last = (corner_reg == 2'd3);
        stat.out_full    = oval_reg && !out_ready;
    end

    assign out_valid  = oval_reg;
    assign out_tsd    = otsd_reg;
    assign out_weight = ow_reg;
    assign out_unseen = oun_reg;
    assign out_status = ost_reg;

`ifndef NO_ASSERTIONS
    a_ready_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ready_reg) |-> ready_reg)
        else $error("grid ready flag dropped");

    a_post_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.post |=> oval_reg)
        else $error("posted result not presented");
`endif

endmodule

// ===== rtl/tsdf_cell_fusion_grid_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdf_cell_fusion_grid_core: tsdf cell fusion grid
// weighted running average fusion into a (CELLS_X+1)x(CELLS_Y+1) cell grid
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one command word (fuse, emptiness pass, bilinear read,
//   initialise); out_ch returns exactly one result word for each accepted word
//   one word in flight at a time; in_ch.ready is high while the sequencer idles
//   steps of each command before out_ch.valid, with
//   N = (CELLS_X+1)*(CELLS_Y+1) cells and a divider for 44-bit dividends:
//     fuse: two passes of the shared restoring divider
//     emptiness pass: the divider walking every one of the N cells
//     bilinear read: four reads of the single memory port
//     initialise: all N cells, one cell written a cycle
//     not-ready and skipped words, and initialise on a ready grid, post
//     their status without writing any cell
//   reset clears the configuration to its defaults, the grid ready flag and
//   the pending weight; cell contents stay undefined until initialise
//   a stalled receiver holds the result in the output register; the next
//   word is taken meanwhile and waits for that register before posting
//   configuration writes on cfg_we are taken in any cycle
// ----------------------------------------------------------------------------
module tsdf_cell_fusion_grid_core #(
    parameter int CELLS_X = tsdf_pkg::DEF_CELLS_X,
    parameter int CELLS_Y = tsdf_pkg::DEF_CELLS_Y
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tsdf_in_if.sink                         in_ch,
    tsdf_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [tsdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsdf_pkg::CFG_W-1:0]      cfg_data
);
    import tsdf_pkg::*;

    ctrl_cmd_t ctrl;
    dp_stat_t  stat;
    logic      in_ready;

    // sequencer
    tsdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // grid datapath with output register
    tsdf_dp #(
        .CELLS_X (CELLS_X),
        .CELLS_Y (CELLS_Y)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_cmd     (in_ch.cmd),
        .in_cell_x  (in_ch.cell_x),
        .in_cell_y  (in_ch.cell_y),
        .in_sdf     (in_ch.sdf),
        .in_frac_x  (in_ch.frac_x),
        .in_frac_y  (in_ch.frac_y),
        .ctrl       (ctrl),
        .stat       (stat),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_tsd    (out_ch.tsd_out),
        .out_weight (out_ch.weight_out),
        .out_unseen (out_ch.unseen),
        .out_status (out_ch.status)
    );

    assign in_ch.ready = in_ready;

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ready) |=> !in_ready)
        else $error("second word taken while one is in flight");
`endif

endmodule

// ===== tb/sv/tsdf_cell_fusion_grid_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdf_cell_fusion_grid_core_test: self-checking bench for the tsdf fusion grid
// drives command words over the valid/ready input channel, keeps its own model
// of the cell grid and compares every result word field by field; runs
// directed corner cases, then random traffic under several register settings
// and idle patterns, including a long receiver hold-off
// ----------------------------------------------------------------------------
module tsdf_cell_fusion_grid_core_test;
    import tsdf_pkg::*;

    localparam int GX         = DEF_CELLS_X + 1;
    localparam int GRID_CELLS = (DEF_CELLS_X + 1) * (DEF_CELLS_Y + 1);
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic signed [TSD_W-1:0] tsd;
        logic [WGT_W-1:0]        wgt;
        logic                    unseen;
        logic [STAT_W-1:0]       status;
    } grid_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    tsdf_in_if  in_ch ();
    tsdf_out_if out_ch ();

    tsdf_cell_fusion_grid_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the grid and the registers
    logic signed [TSD_W-1:0] dist_sh   [GRID_CELLS];
    logic [WGT_W-1:0]        wgt_sh    [GRID_CELLS];
    logic                    unseen_sh [GRID_CELLS];
    logic                    ready_sh;
    longint                  pend_sh;
    longint                  trunc_sh;
    longint                  step_sh;
    longint                  maxw_sh;

    grid_result_t result_words_due [$];

    int     fail_count;
    int     words_checked;
    int     cmd_count [4];
    int     tx_idle_pct;
    int     rx_stall_pct;
    int     hold_cycles;
    longint cycle_count;
    bit     seeded_grid;

    // clock: 8 ns period
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // watchdog on the whole run
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, result_words_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when requested
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles  <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else if (rx_stall_pct > 0)
            out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        else
            out_ch.ready <= 1'b1;
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin
        grid_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (result_words_due.size() == 0)
            begin
                $error("result word with no prediction waiting");
                fail_count++;
            end
            else
            begin
                want = result_words_due.pop_front();
                words_checked++;
                if (out_ch.tsd_out !== want.tsd)
                begin
                    $error("tsd_out expected %0d actual %0d", want.tsd, out_ch.tsd_out);
                    fail_count++;
                end
                if (out_ch.weight_out !== want.wgt)
                begin
                    $error("weight_out expected %0d actual %0d", want.wgt, out_ch.weight_out);
                    fail_count++;
                end
                if (out_ch.unseen !== want.unseen)
                begin
                    $error("unseen expected %0d actual %0d", want.unseen, out_ch.unseen);
                    fail_count++;
                end
                if (out_ch.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, out_ch.status);
                    fail_count++;
                end
            end
        end
    end

    function automatic longint clamp_q12(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // fold one distance into a shadow cell
    task automatic fold_shadow_cell(int idx, longint t, longint step);
        longint w;
        longint prior;
        longint denom;
        longint num;
        longint d;
        w = longint'(wgt_sh[idx]) + step;
        if (unseen_sh[idx])
        begin
            if (w > 65535)
                w = 65535;
            dist_sh[idx]   = t[15:0];
            wgt_sh[idx]    = w[15:0];
            unseen_sh[idx] = 1'b0;
        end
        else
        begin
            if (w > maxw_sh)
                w = maxw_sh;
            prior = (w > step) ? w - step : 0;
            denom = prior + step;
            wgt_sh[idx] = w[15:0];
            if (denom != 0)
            begin
                num = longint'(dist_sh[idx]) * prior + t * step;
                d   = clamp_q12(num / denom);
                dist_sh[idx] = d[15:0];
            end
        end
    endtask

    // expected result word of one accepted command, updating the shadow grid
    task automatic compute_grid_result(input cmd_code_t cmd, input logic [4:0] cx_in,
                                       input logic [4:0] cy_in,
                                       input logic signed [31:0] sdf,
                                       input logic [11:0] fx_in, input logic [11:0] fy_in,
                                       output grid_result_t res);
        longint tr;
        longint t;
        longint cap;
        longint sum;
        longint gx;
        longint gy;
        longint fx;
        longint fy;
        int cx;
        int cy;
        int i00;
        res = '0;
        cx  = int'(cx_in);
        cy  = int'(cy_in);
        fx  = longint'(fx_in);
        fy  = longint'(fy_in);
        case (cmd)
            CMD_FUSE:
            begin
                if (!ready_sh)
                    res.status = RES_NOT_READY;
                else
                begin
                    tr = (trunc_sh != 0) ? trunc_sh : 1;
                    if (longint'(sdf) < -2 * tr)
                        res.status = RES_SKIPPED;
                    else
                    begin
                        t   = (longint'(sdf) * ONE_Q12) / tr;
                        cap = step_sh * 16;
                        if (t > cap)
                            t = cap;
                        t = clamp_q12(t);
                        if (cx > DEF_CELLS_X)
                            cx = DEF_CELLS_X;
                        if (cy > DEF_CELLS_Y)
                            cy = DEF_CELLS_Y;
                        i00 = cy * GX + cx;
                        fold_shadow_cell(i00, t, step_sh);
                        res.tsd = dist_sh[i00];
                        res.wgt = wgt_sh[i00];
                        res.status = RES_DONE;
                    end
                end
            end
            CMD_EMPTY:
            begin
                if (!ready_sh)
                begin
                    pend_sh = pend_sh + ONE_Q8;
                    if (pend_sh > maxw_sh)
                        pend_sh = maxw_sh;
                    res.status = RES_NOT_READY;
                end
                else
                begin
                    for (int i = 0; i < GRID_CELLS; i++)
                        fold_shadow_cell(i, ONE_Q12, ONE_Q8);
                end
            end
            CMD_READ:
            begin
                if (!ready_sh)
                    res.status = RES_NOT_READY;
                else
                begin
                    if (cx > DEF_CELLS_X - 1)
                        cx = DEF_CELLS_X - 1;
                    if (cy > DEF_CELLS_Y - 1)
                        cy = DEF_CELLS_Y - 1;
                    i00 = cy * GX + cx;
                    if (unseen_sh[i00] || unseen_sh[i00 + 1] ||
                        unseen_sh[i00 + GX] || unseen_sh[i00 + GX + 1])
                        res.unseen = 1'b1;
                    else
                    begin
                        gx  = ONE_Q12 - fx;
                        gy  = ONE_Q12 - fy;
                        sum = longint'(dist_sh[i00]) * gy * gx
                            + longint'(dist_sh[i00 + GX]) * fy * gx
                            + longint'(dist_sh[i00 + 1]) * gy * fx
                            + longint'(dist_sh[i00 + GX + 1]) * fy * fx;
                        // round to nearest, ties upward: floor of (sum + half) / 2^24
                        t = (sum + 64'sd8388608) >>> 24;
                        t = clamp_q12(t);
                        res.tsd = t[15:0];
                    end
                end
            end
            default:
            begin
                if (!ready_sh)
                begin
                    for (int i = 0; i < GRID_CELLS; i++)
                    begin
                        dist_sh[i]   = (pend_sh > 0) ? TSD_W'(ONE_Q12) : '0;
                        unseen_sh[i] = (pend_sh == 0);
                        wgt_sh[i]    = pend_sh[15:0];
                    end
                    ready_sh = 1'b1;
                end
            end
        endcase
    endtask

    // offer one command word; predicts at the accepting edge
    task automatic send_word(input cmd_code_t cmd, input logic [4:0] cx, input logic [4:0] cy,
                             input logic signed [31:0] sdf,
                             input logic [11:0] fx, input logic [11:0] fy);
        grid_result_t res;
        while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid  <= 1'b1;
        in_ch.cmd    <= cmd;
        in_ch.cell_x <= cx;
        in_ch.cell_y <= cy;
        in_ch.sdf    <= sdf;
        in_ch.frac_x <= fx;
        in_ch.frac_y <= fy;
        do
            @(posedge clk);
        while (!in_ch.ready);
        compute_grid_result(cmd, cx, cy, sdf, fx, fy, res);
        result_words_due.push_back(res);
        cmd_count[cmd]++;
    endtask

    // let all due words come back, then a short quiet spell
    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (result_words_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // write all three registers on consecutive cycles; only while idle
    task automatic write_regs(input longint trunc, input longint step, input longint maxw);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TRUNC;
        cfg_data  <= trunc[30:0];
        @(negedge clk);
        cfg_index <= REG_STEP;
        cfg_data  <= CFG_W'(step[12:0]);
        @(negedge clk);
        cfg_index <= REG_MAXW;
        cfg_data  <= CFG_W'(maxw[15:0]);
        @(negedge clk);
        cfg_we    <= 1'b0;
        trunc_sh = trunc & 64'h7FFF_FFFF;
        step_sh  = step & 64'h1FFF;
        maxw_sh  = maxw & 64'hFFFF;
    endtask

    // signed distance near the truncation band, or anywhere in the field
    function automatic logic signed [31:0] pick_sdf();
        longint tr;
        longint v;
        tr = (trunc_sh != 0) ? trunc_sh : 1;
        if ($urandom_range(0, 99) < 70)
        begin
            v = longint'($urandom_range(0, 1000)) * 6 * tr / 1000 - 3 * tr;
            if (v > 2147483647)
                v = 2147483647;
            if (v < -2147483648)
                v = -2147483648;
            return v[31:0];
        end
        return $urandom();
    endfunction

    function automatic logic [4:0] pick_cell();
        if ($urandom_range(0, 99) < 85)
            return 5'($urandom_range(0, 16));
        return 5'($urandom_range(0, 31));
    endfunction

    // before the grid exists every command but initialise answers not ready; an emptiness
    // pass here builds up the seed weight, so only a seeded run sends one
    task automatic test_not_ready();
        send_word(CMD_FUSE, 5'd3, 5'd4, 32'sd65536, 12'd0, 12'd0);
        send_word(CMD_READ, 5'd31, 5'd31, 32'sd0, 12'hFFF, 12'hFFF);
        if (seeded_grid)
        begin
            send_word(CMD_EMPTY, 5'd0, 5'd0, 32'sd0, 12'd0, 12'd0);
            send_word(CMD_EMPTY, 5'd0, 5'd0, 32'sd0, 12'd0, 12'd0);
            // pending weight saturating at a low weight limit
            write_regs(TRUNC_RST, STEP_RST, 300);
            send_word(CMD_EMPTY, 5'd0, 5'd0, 32'sd0, 12'd0, 12'd0);
            write_regs(TRUNC_RST, STEP_RST, MAXW_RST);
        end
    endtask

    // initialise, then a second initialise that must leave the grid alone
    task automatic test_init();
        send_word(CMD_INIT, 5'd0, 5'd0, 32'sd0, 12'd0, 12'd0);
        send_word(CMD_INIT, 5'd7, 5'd7, -32'sd5, 12'd1, 12'd1);
    endtask

    // field extremes of fuse and read, saturating indices, threshold edges
    task automatic test_directed();
        // read before any fuse: unseen corners when the grid started empty
        send_word(CMD_READ, 5'd15, 5'd15, 32'sd0, 12'd2048, 12'd2048);
        send_word(CMD_FUSE, 5'd0, 5'd0, 32'sh7FFF_FFFF, 12'd0, 12'd0);
        send_word(CMD_FUSE, 5'd0, 5'd0, 32'sh8000_0000, 12'hFFF, 12'hFFF);
        // exactly at minus twice the truncation: still fused
        send_word(CMD_FUSE, 5'd1, 5'd0, -32'sd131072, 12'd0, 12'd0);
        send_word(CMD_FUSE, 5'd1, 5'd0, -32'sd131073, 12'd0, 12'd0);
        send_word(CMD_FUSE, 5'd31, 5'd31, 32'sd32768, 12'd0, 12'd0);
        send_word(CMD_FUSE, 5'd16, 5'd16, -32'sd1000, 12'd0, 12'd0);
        send_word(CMD_FUSE, 5'd16, 5'd0, 32'sd0, 12'd0, 12'd0);
        send_word(CMD_FUSE, 5'd0, 5'd16, 32'sd70000, 12'd0, 12'd0);
        send_word(CMD_READ, 5'd0, 5'd0, 32'sd0, 12'd0, 12'd0);
        send_word(CMD_READ, 5'd0, 5'd0, 32'sd0, 12'hFFF, 12'hFFF);
        send_word(CMD_READ, 5'd31, 5'd31, 32'sd0, 12'hFFF, 12'd0);
        send_word(CMD_EMPTY, 5'd0, 5'd0, 32'sd0, 12'd0, 12'd0);
        send_word(CMD_READ, 5'd31, 5'd31, 32'sd0, 12'd0, 12'hFFF);
        send_word(CMD_READ, 5'd15, 5'd15, 32'sd0, 12'd2048, 12'd2048);
        // zero truncation acts as one
        write_regs(0, 4096, 65535);
        send_word(CMD_FUSE, 5'd2, 5'd2, 32'sd1, 12'd0, 12'd0);
        send_word(CMD_FUSE, 5'd2, 5'd2, -32'sd2, 12'd0, 12'd0);
        send_word(CMD_FUSE, 5'd2, 5'd2, -32'sd3, 12'd0, 12'd0);
    endtask

    // random mix of commands; emptiness passes kept rare as they sweep the grid
    task automatic test_random(int n);
        int r;
        cmd_code_t cmd;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 999);
            if (r < 620)
                cmd = CMD_FUSE;
            else if (r < 960)
                cmd = CMD_READ;
            else if (r < 995)
                cmd = CMD_INIT;
            else
                cmd = CMD_EMPTY;
            send_word(cmd, pick_cell(), pick_cell(), pick_sdf(),
                      12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        drain_results();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        @(posedge clk);
        hold_cycles = 600;
        test_random(10);
        drain_results();
    endtask

    initial
    begin
        fail_count    = 0;
        words_checked = 0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_cycles   = 0;
        foreach (cmd_count[k])
            cmd_count[k] = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_TRUNC;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.cmd    = CMD_FUSE;
        in_ch.cell_x = '0;
        in_ch.cell_y = '0;
        in_ch.sdf    = '0;
        in_ch.frac_x = '0;
        in_ch.frac_y = '0;
        out_ch.ready = 1'b0;

        // shadow state after reset; cell contents are never read before init
        ready_sh = 1'b0;
        pend_sh  = 0;
        trunc_sh = TRUNC_RST;
        step_sh  = STEP_RST;
        maxw_sh  = MAXW_RST;
        foreach (dist_sh[k])
        begin
            dist_sh[k]   = '0;
            wgt_sh[k]    = '0;
            unseen_sh[k] = 1'b0;
        end

        // a grid is either seeded from a pending weight or starts empty;
        // the seed decides which one this run sees
        seeded_grid = 1'($urandom_range(0, 1));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_not_ready();
        test_init();
        test_directed();

        // register settings: defaults, both extremes, then random ones
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: write_regs(TRUNC_RST, STEP_RST, MAXW_RST);
                1: write_regs(1, 4096, 65535);
                2: write_regs(64'h7FFF_FFFF, 1, 1);
                3: write_regs($urandom_range(1, 2000000), $urandom_range(1, 4096),
                              $urandom_range(1, 65535));
                4: write_regs($urandom_range(1, 32'h7FFF_FFFF), $urandom_range(1, 4096),
                              $urandom_range(1, 65535));
                default: write_regs($urandom_range(1, 300000), $urandom_range(1, 64),
                                    $urandom_range(1, 2000));
            endcase
            case (p % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 74;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 74;
                end
                default:
                begin
                    tx_idle_pct  = 15;
                    rx_stall_pct = 15;
                end
            endcase
            test_random(238);
        end

        test_backpressure();

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        drain_results();
        repeat (100) @(posedge clk);

        $display("covered %0d fuse, %0d emptiness, %0d read, %0d init words (%s grid)",
                 cmd_count[CMD_FUSE], cmd_count[CMD_EMPTY], cmd_count[CMD_READ],
                 cmd_count[CMD_INIT], seeded_grid ? "seeded" : "empty");
        $display("%0d result words checked over six register settings, %0d mismatches",
                 words_checked, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
